// ===== hdl/due_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// due_pkg
// Shared types and constants of the binary64 almost-equal comparator.
// ----------------------------------------------------------------------------
package due_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned MagW  = 63;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [MagW-1:0] ExpMask = 63'h7FF0_0000_0000_0000;
  localparam logic [DataW-1:0] UlpTolReset = 64'd4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ABS_TOL = 8'd0,
    REG_ULP_TOL = 8'd1
  } cfg_reg_e;

  typedef struct packed {
    logic any_nan;
    logic any_inf;
    logic inf_eq;
    logic ulp_ok;
    logic diff_nan;
  } flags_t;

  typedef struct packed {
    flags_t          flags;
    logic            eff_sub;
    logic [MagW-1:0] x_mag;
    logic [MagW-1:0] y_mag;
  } s1_t;

  typedef struct packed {
    flags_t      flags;
    logic        eff_sub;
    logic [55:0] mx;
    logic [55:0] my;
    logic [10:0] exx;
  } s2_t;

  typedef struct packed {
    flags_t      flags;
    logic [56:0] sum;
    logic [5:0]  lz;
    logic [10:0] exx;
  } s3_t;

  typedef struct packed {
    flags_t      flags;
    logic [55:0] m;
    logic [11:0] ex;
  } s4_t;

  typedef struct packed {
    flags_t          flags;
    logic [MagW-1:0] dmag;
  } s5_t;

endpackage

// ===== hdl/due_align.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// due_align
// Unpacks the larger and smaller magnitude and aligns the smaller one
// with guard, round and sticky bits.
// ----------------------------------------------------------------------------
module due_align (
  input  due_pkg::s1_t s1_i,
  output due_pkg::s2_t s2_o
);
  import due_pkg::*;

  logic [10:0]  ex;
  logic [10:0]  ey;
  logic [10:0]  exx;
  logic [10:0]  eyy;
  logic [10:0]  ediff;
  logic [5:0]   dc;
  logic [111:0] wide;
  logic [111:0] shifted;

  always_comb begin
    ex      = s1_i.x_mag[62:52];
    ey      = s1_i.y_mag[62:52];
    exx     = (ex == 11'd0) ? 11'd1 : ex;
    eyy     = (ey == 11'd0) ? 11'd1 : ey;
    ediff   = exx - eyy;
    dc      = (ediff > 11'd57) ? 6'd57 : ediff[5:0];
    wide    = {(ey != 11'd0), s1_i.y_mag[51:0], 59'd0};
    shifted = wide >> dc;

    s2_o.flags   = s1_i.flags;
    s2_o.eff_sub = s1_i.eff_sub;
    s2_o.mx      = {(ex != 11'd0), s1_i.x_mag[51:0], 3'b000};
    s2_o.my      = {shifted[111:57], |shifted[56:0]};
    s2_o.exx     = exx;
  end

endmodule

// ===== hdl/due_addsub.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// due_addsub
// Adds or subtracts the aligned significands and counts leading zeros.
// ----------------------------------------------------------------------------
module due_addsub (
  input  due_pkg::s2_t s2_i,
  output due_pkg::s3_t s3_o
);
  import due_pkg::*;

  logic [56:0] sum;
  logic [5:0]  lz;

  always_comb begin
    if (s2_i.eff_sub) begin
      sum = {1'b0, s2_i.mx} - {1'b0, s2_i.my};
    end else begin
      sum = {1'b0, s2_i.mx} + {1'b0, s2_i.my};
    end
    lz = 6'd57;
    for (int i = 0; i < 57; i++) begin
      if (sum[i]) begin
        lz = 6'(56 - i);
      end
    end
    s3_o.flags = s2_i.flags;
    s3_o.sum   = sum;
    s3_o.lz    = lz;
    s3_o.exx   = s2_i.exx;
  end

endmodule

// ===== hdl/due_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// due_norm
// Normalizes the raw difference, stopping at the subnormal exponent.
// ----------------------------------------------------------------------------
module due_norm (
  input  due_pkg::s3_t s3_i,
  output due_pkg::s4_t s4_o
);
  import due_pkg::*;

  logic [5:0]  lzm1;
  logic [10:0] em1;
  logic [5:0]  lim;
  logic [5:0]  sh;

  always_comb begin
    lzm1 = s3_i.lz - 6'd1;
    em1  = s3_i.exx - 11'd1;
    lim  = (em1 > 11'd63) ? 6'd63 : em1[5:0];
    sh   = (lzm1 < lim) ? lzm1 : lim;
    s4_o.flags = s3_i.flags;
    if (s3_i.sum[56]) begin
      s4_o.m  = {s3_i.sum[56:2], s3_i.sum[1] | s3_i.sum[0]};
      s4_o.ex = {1'b0, s3_i.exx} + 12'd1;
    end else begin
      s4_o.m  = s3_i.sum[55:0] << sh;
      s4_o.ex = {1'b0, s3_i.exx} - {6'd0, sh};
    end
  end

endmodule

// ===== hdl/due_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// due_round
// Rounds the normalized difference to nearest even and packs its magnitude.
// ----------------------------------------------------------------------------
module due_round (
  input  due_pkg::s4_t s4_i,
  output due_pkg::s5_t s5_o
);
  import due_pkg::*;

  logic [10:0]     efield;
  logic [MagW-1:0] base;
  logic            rup;

  always_comb begin
    efield = s4_i.m[55] ? s4_i.ex[10:0] : 11'd0;
    base   = {efield, s4_i.m[54:3]};
    rup    = s4_i.m[2] & (s4_i.m[1] | s4_i.m[0] | s4_i.m[3]);
    s5_o.flags = s4_i.flags;
    if (s4_i.ex >= 12'd2047) begin
      s5_o.dmag = ExpMask;
    end else begin
      s5_o.dmag = base + {62'd0, rup};
    end
  end

endmodule

// ===== hdl/double_ulp_almost_equal_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ulp_almost_equal_core
// The path from the accepting edge to the result register runs through six
// register stages. Throughput is one item per cycle while the output is not
// stalled; the stages carry the subtract, normalize and round path. Each stage
// moves up when the next one has room, so bubbles close up under output stall.
// Reset clears all valid bits and sets the tolerances to 0.0 and 4.
// ----------------------------------------------------------------------------
module double_ulp_almost_equal_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [due_pkg::DataW-1:0]       first_value_i,
  input  logic [due_pkg::DataW-1:0]       second_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            is_close_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [due_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [due_pkg::DataW-1:0]       cfg_data_i
);
  import due_pkg::*;

  logic [DataW-1:0] abs_tol_q;
  logic [DataW-1:0] ulp_tol_q;

  logic [6:1] v_q;
  logic [6:1] en;

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;
  s5_t s5_d, s5_q;
  logic close_d, close_q;

  logic [MagW-1:0] ma, mb, dmag;
  logic [DataW-1:0] ulp_dist;
  logic nan_a, nan_b, inf_a, inf_b, tol_le;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_tol_q <= '0;
      ulp_tol_q <= UlpTolReset;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ABS_TOL: abs_tol_q <= cfg_data_i;
        REG_ULP_TOL: ulp_tol_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    en[6] = !v_q[6] || !out_stall_i;
    for (int k = 5; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[1];

  always_comb begin
    ma    = first_value_i[MagW-1:0];
    mb    = second_value_i[MagW-1:0];
    nan_a = ma > ExpMask;
    nan_b = mb > ExpMask;
    inf_a = ma == ExpMask;
    inf_b = mb == ExpMask;
    if (first_value_i[63] == second_value_i[63]) begin
      ulp_dist = (ma >= mb) ? {1'b0, ma - mb} : {1'b0, mb - ma};
    end else begin
      ulp_dist = {1'b0, ma} + {1'b0, mb};
    end
    s1_d.flags.any_nan  = nan_a | nan_b;
    s1_d.flags.any_inf  = inf_a | inf_b;
    s1_d.flags.inf_eq   = first_value_i == second_value_i;
    s1_d.flags.ulp_ok   = ulp_dist <= ulp_tol_q;
    s1_d.flags.diff_nan = inf_a & inf_b & (first_value_i[63] == second_value_i[63]);
    s1_d.eff_sub        = first_value_i[63] == second_value_i[63];
    s1_d.x_mag          = (ma >= mb) ? ma : mb;
    s1_d.y_mag          = (ma >= mb) ? mb : ma;
  end

  due_align  u_align  (.s1_i(s1_q), .s2_o(s2_d));
  due_addsub u_addsub (.s2_i(s2_q), .s3_o(s3_d));
  due_norm   u_norm   (.s3_i(s3_q), .s4_o(s4_d));
  due_round  u_round  (.s4_i(s4_q), .s5_o(s5_d));

  always_comb begin
    dmag = s5_q.flags.any_inf ? ExpMask : s5_q.dmag;
    if (abs_tol_q[MagW-1:0] > ExpMask) begin
      tol_le = 1'b0;
    end else if (abs_tol_q[63]) begin
      tol_le = (dmag == '0) && (abs_tol_q[MagW-1:0] == '0);
    end else begin
      tol_le = dmag <= abs_tol_q[MagW-1:0];
    end
    if (s5_q.flags.any_nan) begin
      close_d = 1'b0;
    end else if (!s5_q.flags.diff_nan && tol_le) begin
      close_d = 1'b1;
    end else if (s5_q.flags.any_inf) begin
      close_d = s5_q.flags.inf_eq;
    end else begin
      close_d = s5_q.flags.ulp_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= in_valid_i;
      for (int k = 2; k <= 6; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) s1_q <= s1_d;
    if (en[2]) s2_q <= s2_d;
    if (en[3]) s3_q <= s3_d;
    if (en[4]) s4_q <= s4_d;
    if (en[5]) s5_q <= s5_d;
    if (en[6]) close_q <= close_d;
  end

  assign out_valid_o = v_q[6];
  assign is_close_o  = close_q;

  // A stalled input means every stage holds an item.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v_q == 6'b111111))
    else $error("input stalled with an empty stage");

  // An item with a NaN operand never reports close.
  a_nan_false: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[5] && en[6] && s5_q.flags.any_nan) |=> !is_close_o)
    else $error("NaN operand reported close");

  // The output stage only loads when it is empty or being drained.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[6] && out_stall_i) |-> !en[5] || !v_q[5] || !en[6])
    else $error("stage advanced into a blocked output");

endmodule
